// File: hw/rtl/mcvf_pkg.sv
// Shared types and codes of the multi-channel volume fader.
// Item layouts of the input and result channels; no dependencies.
package mcvf_pkg;

    localparam int KIND_W    = 2;
    localparam int CHANNEL_W = 5;
    localparam int LEVEL_W   = 9;
    localparam int FADE_W    = 16;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int VOLUME_W  = 8;
    localparam int ACTIVE_W  = 5;

    localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CH  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_VOL = 2'd2;

    localparam logic [VOLUME_W-1:0] MAX_VOLUME = 8'd255;

    localparam int DIV_STEPS = VOLUME_W;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [CHANNEL_W-1:0] channel;
        logic [LEVEL_W-1:0]   level;
        logic [FADE_W-1:0]    fade_ms;
        logic [TIME_W-1:0]    now_ms;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VOLUME_W-1:0] volume;
        logic [ACTIVE_W-1:0] active_fades;
    } t_out_item;

endpackage

// File: hw/rtl/mcvf_stream_if.sv
// Valid/ready stream channel of the volume fader.
// Payload type is set by the instantiating level; no package dependency.
interface mcvf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/multi_channel_volume_fader_unit.sv
// Top level of the multi-channel volume fader: slot volumes, fade table, tick walk.
// Depends on mcvf_pkg and mcvf_stream_if.
//
// The block holds an 8-bit volume for each of CHANNELS sound slots plus one music slot
// (index CHANNELS) in a one-port-read synchronous memory, and each slot's pending fade
// (start time, end time, start and final volume) in a second one. One item is worked
// at a time. A set or read item reads its slot's volume, is checked in S_RD and passes
// S_DONE into the output register. A tick walks every slot in index order: an idle slot
// is skipped, a fade that ends writes its final volume, and a fade in progress passes
// S_CALC, S_PREP, S_MUL, S_DIV and S_APPLY, where an 8-step restoring divider of
// elapsed * delta by the fade duration sets the figure. Volumes read as 255
// and no fade is pending right after reset, with no clearing pass. A finished result
// waits in an output register while the next item is taken.
module multi_channel_volume_fader_unit
    import mcvf_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcvf_stream_if.sink   i_in,
    mcvf_stream_if.source o_out
);

    localparam int NUM_SLOTS = CHANNELS + 1;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int PROD_W    = FADE_W + VOLUME_W;

    typedef struct packed {
        logic [TIME_W-1:0]   from_ms;
        logic [TIME_W-1:0]   to_ms;
        logic [VOLUME_W-1:0] start_vol;
        logic [VOLUME_W-1:0] final_vol;
    } t_fade;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DONE,
        S_SCAN,
        S_CALC,
        S_PREP,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_TICK_RD
    } t_state;

    t_state               r_state, n_state;
    t_in_item             r_item, n_item;
    logic [CNT_W-1:0]     r_slot, n_slot;
    logic [NUM_SLOTS-1:0] r_vol_valid, n_vol_valid;
    logic [NUM_SLOTS-1:0] r_active, n_active;
    logic [CNT_W-1:0]     r_active_cnt, n_active_cnt;
    t_out_item            r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic [VOLUME_W-1:0]  r_sv, n_sv;
    logic [VOLUME_W-1:0]  r_fv, n_fv;
    logic                 r_neg, n_neg;
    logic [VOLUME_W-1:0]  r_mag, n_mag;
    logic [TIME_W-1:0]    r_el32, n_el32;
    logic [FADE_W-1:0]    r_el, n_el;
    logic [FADE_W-1:0]    r_dur, n_dur;
    logic [FADE_W-1:0]    r_rem, n_rem;
    logic [VOLUME_W-1:0]  r_lo, n_lo;
    logic [STEP_W-1:0]    r_step, n_step;

    logic [VOLUME_W-1:0]  r_vol_mem [NUM_SLOTS];
    logic [VOLUME_W-1:0]  r_vol_rd;
    t_fade                r_fade_mem [NUM_SLOTS];
    t_fade                r_fade_rd;

    logic                 vol_we, vol_re, fade_we, fade_re;
    logic [SLOT_W-1:0]    vol_waddr, vol_raddr, fade_waddr, fade_raddr;
    logic [VOLUME_W-1:0]  vol_wdata;
    t_fade                fade_wdata;

    logic [SLOT_W-1:0]    item_slot, walk_slot;
    logic                 item_ch_ok;
    logic [VOLUME_W-1:0]  cur_vol;
    logic                 out_room;
    logic [TIME_W-1:0]    calc_dur32;
    logic [PROD_W-1:0]    prod;
    logic [FADE_W:0]      div_shift, div_diff;
    logic                 div_qb;
    logic [VOLUME_W+1:0]  v_sum;
    logic [VOLUME_W-1:0]  v_clamped;

    assign item_slot  = SLOT_W'(r_item.channel);
    assign walk_slot  = r_slot[SLOT_W-1:0];
    assign item_ch_ok = 32'(r_item.channel) <= CHANNELS;
    assign cur_vol    = r_vol_valid[item_slot] ? r_vol_rd : MAX_VOLUME;
    assign out_room   = !r_out_valid || o_out.ready;

    assign calc_dur32 = r_fade_rd.to_ms - r_fade_rd.from_ms;
    assign prod       = PROD_W'(r_el) * PROD_W'(r_mag);
    assign div_shift  = {r_rem, r_lo[VOLUME_W-1]};
    assign div_diff   = div_shift - {1'b0, r_dur};
    assign div_qb     = !div_diff[FADE_W];
    assign v_sum      = r_neg ? ({2'b00, r_sv} - {2'b00, r_lo})
                              : ({2'b00, r_sv} + {2'b00, r_lo});
    assign v_clamped  = v_sum[VOLUME_W+1] ? '0 :
                        (v_sum[VOLUME_W] ? MAX_VOLUME : v_sum[VOLUME_W-1:0]);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_slot       = r_slot;
        n_vol_valid  = r_vol_valid;
        n_active     = r_active;
        n_active_cnt = r_active_cnt;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        n_sv         = r_sv;
        n_fv         = r_fv;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_el32       = r_el32;
        n_el         = r_el;
        n_dur        = r_dur;
        n_rem        = r_rem;
        n_lo         = r_lo;
        n_step       = r_step;
        vol_we       = 1'b0;
        vol_waddr    = item_slot;
        vol_wdata    = r_item.level[VOLUME_W-1:0];
        vol_re       = 1'b0;
        vol_raddr    = item_slot;
        fade_we      = 1'b0;
        fade_waddr   = item_slot;
        fade_wdata   = '{from_ms:   r_item.now_ms,
                         to_ms:     r_item.now_ms + TIME_W'(r_item.fade_ms),
                         start_vol: cur_vol,
                         final_vol: r_item.level[VOLUME_W-1:0]};
        fade_re      = 1'b0;
        fade_raddr   = walk_slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_item = i_in.data;
                    n_slot = '0;
                    if (i_in.data.kind == KIND_TICK) begin
                        n_state = S_SCAN;
                    end else begin
                        vol_re    = 1'b1;
                        vol_raddr = SLOT_W'(i_in.data.channel);
                        n_state   = S_RD;
                    end
                end
            end
            S_RD: begin
                n_res.volume = item_ch_ok ? cur_vol : '0;
                if (!item_ch_ok) begin
                    n_res.status = STATUS_BAD_CH;
                end else if (r_item.kind == KIND_SET && r_item.level[LEVEL_W-1]) begin
                    n_res.status = STATUS_BAD_VOL;
                end else begin
                    n_res.status = STATUS_OK;
                end
                if (item_ch_ok && r_item.kind == KIND_SET && !r_item.level[LEVEL_W-1]) begin
                    if (r_item.fade_ms == '0) begin
                        vol_we                 = 1'b1;
                        n_vol_valid[item_slot] = 1'b1;
                        n_res.volume           = r_item.level[VOLUME_W-1:0];
                    end else begin
                        fade_we = 1'b1;
                        if (!r_active[item_slot]) begin
                            n_active_cnt = r_active_cnt + CNT_W'(1);
                        end
                        n_active[item_slot] = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_room) begin
                    n_out              = r_res;
                    n_out.active_fades = ACTIVE_W'(r_active_cnt);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_slot == CNT_W'(NUM_SLOTS)) begin
                    n_state = S_TICK_RD;
                end else if (r_active[walk_slot]) begin
                    fade_re = 1'b1;
                    n_state = S_CALC;
                end else begin
                    n_slot = r_slot + CNT_W'(1);
                end
            end
            S_CALC: begin
                n_sv   = r_fade_rd.start_vol;
                n_fv   = r_fade_rd.final_vol;
                n_dur  = calc_dur32[FADE_W-1:0];
                n_el32 = (r_item.now_ms >= r_fade_rd.from_ms)
                       ? (r_item.now_ms - r_fade_rd.from_ms) : '0;
                if (r_item.now_ms >= r_fade_rd.to_ms) begin
                    vol_we                 = 1'b1;
                    vol_waddr              = walk_slot;
                    vol_wdata              = r_fade_rd.final_vol;
                    n_vol_valid[walk_slot] = 1'b1;
                    n_active[walk_slot]    = 1'b0;
                    n_active_cnt           = r_active_cnt - CNT_W'(1);
                    n_slot                 = r_slot + CNT_W'(1);
                    n_state                = S_SCAN;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_el    = (r_el32 > TIME_W'(r_dur)) ? r_dur : r_el32[FADE_W-1:0];
                n_neg   = r_fv < r_sv;
                n_mag   = (r_fv < r_sv) ? (r_sv - r_fv) : (r_fv - r_sv);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_rem   = prod[PROD_W-1:VOLUME_W];
                n_lo    = prod[VOLUME_W-1:0];
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = div_qb ? div_diff[FADE_W-1:0] : div_shift[FADE_W-1:0];
                n_lo   = {r_lo[VOLUME_W-2:0], div_qb};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                vol_we                 = 1'b1;
                vol_waddr              = walk_slot;
                vol_wdata              = v_clamped;
                n_vol_valid[walk_slot] = 1'b1;
                n_slot                 = r_slot + CNT_W'(1);
                n_state                = S_SCAN;
            end
            S_TICK_RD: begin
                vol_re  = 1'b1;
                n_state = S_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_out  <= n_out;
        r_sv   <= n_sv;
        r_fv   <= n_fv;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_el32 <= n_el32;
        r_el   <= n_el;
        r_dur  <= n_dur;
        r_rem  <= n_rem;
        r_lo   <= n_lo;
        r_step <= n_step;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vol_valid  <= '0;
            r_active     <= '0;
            r_active_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_vol_valid  <= n_vol_valid;
            r_active     <= n_active;
            r_active_cnt <= n_active_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vol_we) begin
            r_vol_mem[vol_waddr] <= vol_wdata;
        end
        if (vol_re) begin
            r_vol_rd <= r_vol_mem[vol_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fade_we) begin
            r_fade_mem[fade_waddr] <= fade_wdata;
        end
        if (fade_re) begin
            r_fade_rd <= r_fade_mem[fade_raddr];
        end
    end

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_active_cnt) == $countones(r_active))
        else $error("fade counter out of step with active bits");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dur))
        else $error("divider remainder not below duration");

    a_bad_channel_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == STATUS_BAD_CH) |-> (o_out.data.volume == '0))
        else $error("invalid channel result carries a volume");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_out.ready) |=> (r_state == S_DONE))
        else $error("result dropped while output register full");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_channel_volume_fader_unit: directed and random set, tick, read
// and spare-kind commands, with results checked against an in-bench fade predictor.
// Depends on mcvf_pkg and mcvf_stream_if.
module tb;
    import mcvf_pkg::*;

    localparam int CHANNELS  = 16;
    localparam int NUM_SLOTS = CHANNELS + 1;
    localparam int RANDOM_CMDS = 500;
    localparam int HOLD_AT = 320;
    localparam int HOLD_CYCLES = 400;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;

    mcvf_stream_if #(.T(t_in_item))  in_ch ();
    mcvf_stream_if #(.T(t_out_item)) out_ch ();

    multi_channel_volume_fader_unit #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [VOLUME_W-1:0] slot_level [NUM_SLOTS];
    logic                ramp_on    [NUM_SLOTS];
    logic [TIME_W-1:0]   ramp_t0    [NUM_SLOTS];
    logic [TIME_W-1:0]   ramp_t1    [NUM_SLOTS];
    logic [VOLUME_W-1:0] ramp_v0    [NUM_SLOTS];
    logic [VOLUME_W-1:0] ramp_v1    [NUM_SLOTS];

    t_in_item  pending_cmds [$];
    t_out_item expected_results [$];
    t_out_item want;
    int        cmds_total;
    int        cmds_taken;
    int        results_seen;
    int        mismatches;
    int        hold_left;
    bit        hold_done;

    function automatic t_out_item fader_step(input t_in_item it);
        t_out_item         r;
        logic              ch_ok;
        int                slot;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] el;
        longint            diff;
        longint            v;
        ch_ok = (it.channel <= CHANNELS);
        slot = ch_ok ? int'(it.channel) : 0;
        r.status = ch_ok ? STATUS_OK : STATUS_BAD_CH;
        r.volume = '0;
        r.active_fades = '0;
        case (it.kind)
            KIND_SET: begin
                if (ch_ok && it.level > MAX_VOLUME) begin
                    r.status = STATUS_BAD_VOL;
                end
                if (r.status == STATUS_OK) begin
                    if (it.fade_ms == '0) begin
                        slot_level[slot] = it.level[VOLUME_W-1:0];
                    end else begin
                        ramp_on[slot] = 1'b1;
                        ramp_t0[slot] = it.now_ms;
                        ramp_t1[slot] = it.now_ms + TIME_W'(it.fade_ms);
                        ramp_v0[slot] = slot_level[slot];
                        ramp_v1[slot] = it.level[VOLUME_W-1:0];
                    end
                end
            end
            KIND_TICK: begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (ramp_on[s]) begin
                        if (it.now_ms >= ramp_t1[s]) begin
                            slot_level[s] = ramp_v1[s];
                            ramp_on[s] = 1'b0;
                        end else begin
                            dur = ramp_t1[s] - ramp_t0[s];
                            el = (it.now_ms >= ramp_t0[s]) ? it.now_ms - ramp_t0[s] : '0;
                            if (dur == '0) begin
                                slot_level[s] = ramp_v1[s];
                            end else begin
                                if (el > dur) begin
                                    el = dur;
                                end
                                diff = longint'(ramp_v1[s]) - longint'(ramp_v0[s]);
                                v = longint'(ramp_v0[s]) + (longint'(el) * diff) / longint'(dur);
                                if (v < 0) begin
                                    v = 0;
                                end
                                if (v > 255) begin
                                    v = 255;
                                end
                                slot_level[s] = v[VOLUME_W-1:0];
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        for (int s = 0; s < NUM_SLOTS; s++) begin
            r.active_fades += ACTIVE_W'(ramp_on[s]);
        end
        r.volume = ch_ok ? slot_level[slot] : '0;
        return r;
    endfunction

    task automatic push_cmd(input logic [KIND_W-1:0] kind, input int ch, input int lvl,
                            input int fade, input logic [TIME_W-1:0] now);
        t_in_item it;
        it.kind    = kind;
        it.channel = CHANNEL_W'(ch);
        it.level   = LEVEL_W'(lvl);
        it.fade_ms = FADE_W'(fade);
        it.now_ms  = now;
        pending_cmds.insert(pending_cmds.size(), it);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.insert(expected_results.size(), fader_step(in_ch.data));
                cmds_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_cmds.size() != 0 &&
                    ((cmds_taken >= 150 && cmds_taken < 270) || $urandom_range(0, 99) >= 6)) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_cmds.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got status %0d volume %0d active %0d",
                             $time, out_ch.data.status, out_ch.data.volume,
                             out_ch.data.active_fades);
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.data.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, out_ch.data.status);
                    end
                    if (out_ch.data.volume !== want.volume) begin
                        mismatches++;
                        $display("%0t: volume expected %0d, got %0d",
                                 $time, want.volume, out_ch.data.volume);
                    end
                    if (out_ch.data.active_fades !== want.active_fades) begin
                        mismatches++;
                        $display("%0t: active_fades expected %0d, got %0d",
                                 $time, want.active_fades, out_ch.data.active_fades);
                    end
                end
            end
            // hold off once for a long stretch so the block backs up into its input
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= (results_seen >= 150 && results_seen < 270) ||
                                $urandom_range(0, 99) >= 6;
            end
        end
    end

    initial begin
        logic [TIME_W-1:0] t_ms;
        logic [TIME_W-1:0] now;
        int                r;
        int                p;
        int                fade;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_level[s] = MAX_VOLUME;
            ramp_on[s] = 1'b0;
            ramp_t0[s] = '0;
            ramp_t1[s] = '0;
            ramp_v0[s] = '0;
            ramp_v1[s] = '0;
        end

        push_cmd(KIND_READ, 0, 0, 0, 0);
        push_cmd(KIND_READ, CHANNELS, 511, 65535, 32'hFFFF_FFFF);
        push_cmd(KIND_READ, 31, 0, 0, 0);
        push_cmd(KIND_SPARE, 7, 0, 0, 0);
        push_cmd(KIND_SET, 0, 0, 0, 0);
        push_cmd(KIND_SET, CHANNELS, 255, 0, 0);
        push_cmd(KIND_SET, 1, 256, 0, 0);
        push_cmd(KIND_SET, 31, 511, 0, 0);
        push_cmd(KIND_SET, 17, 300, 10, 0);
        push_cmd(KIND_SET, 2, 0, 1000, 1000);
        push_cmd(KIND_TICK, 2, 0, 0, 500);
        push_cmd(KIND_TICK, 2, 511, 65535, 1500);
        push_cmd(KIND_TICK, 2, 0, 0, 2000);
        push_cmd(KIND_SET, 3, 10, 0, 0);
        push_cmd(KIND_SET, 3, 200, 65535, 100);
        push_cmd(KIND_TICK, 3, 0, 0, 30000);
        push_cmd(KIND_SET, 3, 50, 0, 30001);
        push_cmd(KIND_TICK, 31, 0, 0, 70000);
        push_cmd(KIND_SET, 4, 77, 100, 32'hFFFF_FFF0);
        push_cmd(KIND_TICK, 4, 0, 0, 32'hFFFF_FFF8);
        push_cmd(KIND_SET, 5, 0, 500, 100);
        push_cmd(KIND_SET, 5, 128, 50, 200);
        push_cmd(KIND_TICK, 5, 0, 0, 210);
        push_cmd(KIND_TICK, 5, 0, 0, 225);
        push_cmd(KIND_READ, 5, 0, 0, 0);

        t_ms = 32'd1000;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            t_ms += TIME_W'($urandom_range(0, 400));
            p = $urandom_range(0, 99);
            if (p < 2) begin
                t_ms = $urandom();
            end else if (p < 3) begin
                t_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 3000));
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                p = $urandom_range(0, 99);
                fade = (p < 30) ? 0 : (p < 95) ? $urandom_range(1, 2500) : $urandom_range(1, 65535);
                now = ($urandom_range(0, 99) < 5) ? t_ms + TIME_W'($urandom_range(0, 2000)) : t_ms;
                push_cmd(KIND_SET, $urandom_range(0, CHANNELS), $urandom_range(0, 255), fade, now);
            end else if (r < 75) begin
                now = ($urandom_range(0, 99) < 5) ? t_ms - TIME_W'($urandom_range(0, 1000)) : t_ms;
                push_cmd(KIND_TICK, $urandom_range(0, 31), $urandom_range(0, 511),
                         $urandom_range(0, 65535), now);
            end else if (r < 90) begin
                push_cmd(KIND_READ, $urandom_range(0, CHANNELS), $urandom_range(0, 511),
                         $urandom_range(0, 65535), $urandom());
            end else begin
                case ($urandom_range(0, 2))
                    0: push_cmd(KIND_SPARE, $urandom_range(0, 31), $urandom_range(0, 511),
                                $urandom_range(0, 65535), $urandom());
                    1: push_cmd(KIND_SET, $urandom_range(CHANNELS + 1, 31), $urandom_range(0, 511),
                                $urandom_range(0, 65535), t_ms);
                    default: push_cmd(KIND_SET, $urandom_range(0, CHANNELS), $urandom_range(256, 511),
                                      $urandom_range(0, 65535), t_ms);
                endcase
            end
        end
        cmds_total = pending_cmds.size();

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (cmds_taken < cmds_total || expected_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mcvf_pkg.sv
hw/rtl/mcvf_stream_if.sv
hw/rtl/multi_channel_volume_fader_unit.sv
tb/tb.sv
